### hw/rtl/shsc_pkg.sv
package shsc_pkg;

  localparam int PHASE_W = 4;
  localparam int COUNT_W = 5;
  localparam int SPEED_W = 4;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REV  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

  localparam logic [SPEED_W-1:0] SPEED_MAX   = 4'd15;
  localparam logic [SPEED_W-1:0] SPEED_MIN   = 4'd1;
  localparam logic [SPEED_W-1:0] SPEED_START = 4'd8;

  localparam logic [COUNT_W-1:0] DIV_MIN   = 5'd1;
  localparam logic [COUNT_W-1:0] DIV_MAX   = 5'd16;
  localparam logic [COUNT_W-1:0] DIV_START = 5'd8;
  localparam logic [COUNT_W-1:0] COUNT_TOP = 5'd18;

  localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd1;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 4'd8;
  localparam logic [PHASE_W-1:0] PHASE_WRAP  = 4'd9;

  // Half-step coil table; index zero and anything past the last step drive nothing.
  function automatic logic [3:0] coil_pattern(input logic [PHASE_W-1:0] idx);
    logic [3:0] pat;
    case (idx)
      4'd1:    pat = 4'hc;
      4'd2:    pat = 4'h4;
      4'd3:    pat = 4'h6;
      4'd4:    pat = 4'h2;
      4'd5:    pat = 4'h3;
      4'd6:    pat = 4'h1;
      4'd7:    pat = 4'h9;
      4'd8:    pat = 4'h8;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

### hw/rtl/stepper_half_step_controller.sv
// Half-step stepper sequencer.
// Input channel (in_valid/in_ready): one event per transfer. With kind low the
// event is a timer tick; with kind high it is a set of button presses, applied
// in the order faster, slower, forward, reverse, stop, start.
// Output channel (out_valid/out_ready): one result per event, showing the coil
// pattern, step pulse level, speed level, mode, start wait and run flag as they
// stand after that event.
// The result of an event is registered and is valid just after the edge at
// which the event is accepted. Throughput is one event per cycle while the
// receiver takes each result; the whole update is one pass of small adds and
// compares between the state registers and the result register.
// When the receiver stalls, the result register holds its value and in_ready
// drops, so at most one result waits. Reset clears both channels and loads the
// power-on state: stopped, speed zero, divider eight, pulse pin high.
module stepper_half_step_controller
  import shsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic               press_faster,
  input  logic               press_slower,
  input  logic               press_forward,
  input  logic               press_reverse,
  input  logic               press_stop,
  input  logic               press_start,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         phase_pattern,
  output logic               pulse_level,
  output logic [SPEED_W-1:0] speed_level,
  output logic [MODE_W-1:0]  motor_mode,
  output logic               awaiting_start,
  output logic               running
);

  logic [PHASE_W-1:0] phase_index, phase_index_next;
  logic [COUNT_W-1:0] tick_count, tick_count_next;
  logic [COUNT_W-1:0] tick_divider, tick_divider_next;
  logic [SPEED_W-1:0] speed_store, speed_store_next;
  logic [MODE_W-1:0]  mode_store, mode_store_next;
  logic               start_pending, start_pending_next;
  logic               pulse_store, pulse_store_next;
  logic               stopped_next;
  logic               accept;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [PHASE_W-1:0] ph;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] div;
    logic [SPEED_W-1:0] spd;
    logic [MODE_W-1:0]  md;
    logic               pend;
    logic               pls;
    logic               run;

    ph   = phase_index;
    cnt  = tick_count;
    div  = tick_divider;
    spd  = speed_store;
    md   = mode_store;
    pend = start_pending;
    pls  = pulse_store;
    run  = (mode_store == MODE_FWD || mode_store == MODE_REV) && !start_pending;

    if (!kind) begin
      cnt = tick_count + COUNT_W'(1);
      if (cnt == tick_divider) begin
        pls = !pulse_store;
        cnt = '0;
        if (run) begin
          if (mode_store == MODE_FWD) begin
            ph = phase_index + PHASE_W'(1);
          end else if (phase_index == '0) begin
            ph = PHASE_LAST;
          end else begin
            ph = phase_index - PHASE_W'(1);
          end
        end
        if (ph == PHASE_WRAP) begin
          ph = PHASE_FIRST;
        end
        if (ph == '0) begin
          ph = PHASE_LAST;
        end
      end
      if (cnt > COUNT_TOP) begin
        cnt = '0;
      end
    end else begin
      if (press_faster) begin
        spd = (spd < SPEED_MAX) ? spd + SPEED_W'(1) : SPEED_MAX;
        div = (div < 5'd2) ? DIV_MIN : div - COUNT_W'(1);
      end
      if (press_slower) begin
        spd = (spd <= SPEED_MIN) ? SPEED_MIN : spd - SPEED_W'(1);
        div = (div >= DIV_MAX) ? DIV_MAX : div + COUNT_W'(1);
      end
      // Picking a direction from standstill arms the wait for start.
      if (press_forward) begin
        if (md != MODE_FWD && md != MODE_REV) begin
          pend = 1'b1;
        end
        md = MODE_FWD;
      end
      if (press_reverse) begin
        if (md != MODE_FWD && md != MODE_REV) begin
          pend = 1'b1;
        end
        md = MODE_REV;
      end
      if (press_stop) begin
        md = MODE_STOP;
      end
      if (press_start) begin
        spd = SPEED_START;
        if (md != MODE_FWD && md != MODE_REV) begin
          md = MODE_FWD;
        end
        pend = 1'b0;
        div  = DIV_START;
      end
    end

    phase_index_next   = ph;
    tick_count_next    = cnt;
    tick_divider_next  = div;
    speed_store_next   = spd;
    mode_store_next    = md;
    start_pending_next = pend;
    pulse_store_next   = pls;
  end

  assign stopped_next = (mode_store_next != MODE_FWD) && (mode_store_next != MODE_REV);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index   <= '0;
      tick_count    <= '0;
      tick_divider  <= DIV_START;
      speed_store   <= '0;
      mode_store    <= MODE_STOP;
      start_pending <= 1'b0;
      pulse_store   <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase_index   <= phase_index_next;
        tick_count    <= tick_count_next;
        tick_divider  <= tick_divider_next;
        speed_store   <= speed_store_next;
        mode_store    <= mode_store_next;
        start_pending <= start_pending_next;
        pulse_store   <= pulse_store_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid     <= 1'b0;
      end
    end
  end

  // Result register; loaded only on an input transfer, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      phase_pattern  <= coil_pattern(phase_index_next);
      pulse_level    <= pulse_store_next;
      speed_level    <= speed_store_next;
      motor_mode     <= stopped_next ? MODE_STOP : mode_store_next;
      awaiting_start <= start_pending_next;
      running        <= !stopped_next && !start_pending_next;
    end
  end

endmodule

### dv/stepper_half_step_controller_test.sv
module stepper_half_step_controller_test
  import shsc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  // Press masks, ordered {faster, slower, forward, reverse, stop, start}.
  localparam logic [5:0] P_FASTER  = 6'b100000;
  localparam logic [5:0] P_SLOWER  = 6'b010000;
  localparam logic [5:0] P_FORWARD = 6'b001000;
  localparam logic [5:0] P_REVERSE = 6'b000100;
  localparam logic [5:0] P_STOP    = 6'b000010;
  localparam logic [5:0] P_START   = 6'b000001;

  localparam int RANDOM_EVENTS = 1450;

  typedef struct packed {
    logic       kind;
    logic [5:0] presses;
  } motor_evt_t;

  typedef struct packed {
    logic [3:0]         phase_pattern;
    logic               pulse_level;
    logic [SPEED_W-1:0] speed_level;
    logic [MODE_W-1:0]  motor_mode;
    logic               awaiting_start;
    logic               running;
  } motor_status_t;

  class stepper_tracker;
    logic [PHASE_W-1:0] phase_idx;
    logic [COUNT_W-1:0] tick_cnt;
    logic [COUNT_W-1:0] divider;
    logic [SPEED_W-1:0] speed;
    logic [MODE_W-1:0]  mode;
    logic               wait_start;
    logic               pulse;
    logic [3:0]         coil_steps [0:8];
    motor_status_t      pending_status [$];
    int                 errors;

    function new();
      coil_steps = '{4'h0, 4'hc, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9, 4'h8};
      phase_idx  = '0;
      tick_cnt   = '0;
      divider    = DIV_START;
      speed      = '0;
      mode       = MODE_STOP;
      wait_start = 1'b0;
      pulse      = 1'b1;
      errors     = 0;
    endfunction

    function bit stopped();
      return mode != MODE_FWD && mode != MODE_REV;
    endfunction

    function bit moving();
      return !stopped() && !wait_start;
    endfunction

    function void step_phase();
      if (moving()) begin
        if (mode == MODE_FWD) phase_idx = phase_idx + 1'b1;
        else if (phase_idx == '0) phase_idx = PHASE_LAST;
        else phase_idx = phase_idx - 1'b1;
      end
      if (phase_idx == PHASE_WRAP) phase_idx = PHASE_FIRST;
      if (phase_idx == '0) phase_idx = PHASE_LAST;
    endfunction

    // Applies one accepted transfer to the shadow state and queues the status it leaves.
    function void note_event(motor_evt_t evt);
      motor_status_t want;
      if (evt.kind == KIND_TICK) begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt == divider) begin
          pulse    = ~pulse;
          tick_cnt = '0;
          step_phase();
        end
        if (tick_cnt > COUNT_TOP) tick_cnt = '0;
      end else begin
        if (evt.presses & P_FASTER) begin
          speed   = (speed < SPEED_MAX) ? speed + 1'b1 : SPEED_MAX;
          divider = (divider < 2) ? DIV_MIN : divider - 1'b1;
        end
        if (evt.presses & P_SLOWER) begin
          speed   = (speed <= SPEED_MIN) ? SPEED_MIN : speed - 1'b1;
          divider = (divider >= DIV_MAX) ? DIV_MAX : divider + 1'b1;
        end
        if (evt.presses & P_FORWARD) begin
          if (stopped()) wait_start = 1'b1;
          mode = MODE_FWD;
        end
        if (evt.presses & P_REVERSE) begin
          if (stopped()) wait_start = 1'b1;
          mode = MODE_REV;
        end
        if (evt.presses & P_STOP) mode = MODE_STOP;
        if (evt.presses & P_START) begin
          speed = SPEED_START;
          if (stopped()) mode = MODE_FWD;
          wait_start = 1'b0;
          divider    = DIV_START;
        end
      end
      want.phase_pattern  = (phase_idx <= PHASE_LAST) ? coil_steps[phase_idx] : 4'h0;
      want.pulse_level    = pulse;
      want.speed_level    = speed;
      want.motor_mode     = stopped() ? MODE_STOP : mode;
      want.awaiting_start = wait_start;
      want.running        = moving();
      pending_status.push_back(want);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(motor_status_t got);
      motor_status_t want;
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_status.pop_front();
      compare("phase_pattern", 32'(want.phase_pattern), 32'(got.phase_pattern));
      compare("pulse_level", 32'(want.pulse_level), 32'(got.pulse_level));
      compare("speed_level", 32'(want.speed_level), 32'(got.speed_level));
      compare("motor_mode", 32'(want.motor_mode), 32'(got.motor_mode));
      compare("awaiting_start", 32'(want.awaiting_start), 32'(got.awaiting_start));
      compare("running", 32'(want.running), 32'(got.running));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               kind;
  logic               press_faster;
  logic               press_slower;
  logic               press_forward;
  logic               press_reverse;
  logic               press_stop;
  logic               press_start;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         phase_pattern;
  logic               pulse_level;
  logic [SPEED_W-1:0] speed_level;
  logic [MODE_W-1:0]  motor_mode;
  logic               awaiting_start;
  logic               running;

  stepper_tracker sb;
  bit             quiet_span;

  stepper_half_step_controller dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .press_faster   (press_faster),
    .press_slower   (press_slower),
    .press_forward  (press_forward),
    .press_reverse  (press_reverse),
    .press_stop     (press_stop),
    .press_start    (press_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .phase_pattern  (phase_pattern),
    .pulse_level    (pulse_level),
    .speed_level    (speed_level),
    .motor_mode     (motor_mode),
    .awaiting_start (awaiting_start),
    .running        (running)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one event and returns at the edge where the transfer happens.
  task automatic push_event(input logic k, input logic [5:0] presses);
    int gap;
    gap = quiet_span ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    {press_faster, press_slower, press_forward, press_reverse, press_stop, press_start}
      <= presses;
    do @(posedge clk); while (!in_ready);
    sb.note_event('{kind: k, presses: presses});
  endtask

  task automatic collect_status();
    int stall;
    forever begin
      stall = quiet_span ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result('{phase_pattern: phase_pattern, pulse_level: pulse_level,
                        speed_level: speed_level, motor_mode: motor_mode,
                        awaiting_start: awaiting_start, running: running});
    end
  endtask

  initial begin
    logic [5:0] presses;
    sb = new();
    quiet_span = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    kind = KIND_TICK;
    {press_faster, press_slower, press_forward, press_reverse, press_stop, press_start} = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      collect_status();
    join_none

    // A tick ignores whatever buttons ride along with it.
    push_event(KIND_TICK, 6'b111111);
    // Slower from the power-on speed of zero lands on one.
    push_event(KIND_BUTTON, P_SLOWER);
    // Both directions while stopped: reverse wins and the start wait is armed.
    push_event(KIND_BUTTON, P_FORWARD | P_REVERSE);
    push_event(KIND_BUTTON, P_FASTER | P_SLOWER | P_START);
    repeat (6) push_event(KIND_BUTTON, P_FASTER);
    // First expiry while running in reverse from index zero.
    push_event(KIND_TICK, '0);
    repeat (2) push_event(KIND_BUTTON, P_FASTER);
    push_event(KIND_TICK, '0);
    push_event(KIND_BUTTON, P_FORWARD);
    repeat (2) push_event(KIND_TICK, '0);
    push_event(KIND_BUTTON, P_STOP);
    // Expiry while stopped still toggles the pulse pin.
    push_event(KIND_TICK, '0);
    push_event(KIND_BUTTON, P_FORWARD | P_REVERSE | P_STOP);
    push_event(KIND_BUTTON, P_SLOWER);
    push_event(KIND_TICK, '0);
    // Divider drops to the count, so the next tick overshoots it.
    push_event(KIND_BUTTON, P_FASTER);
    push_event(KIND_TICK, '0);

    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      quiet_span = ((i / 50) % 5) == 4;
      if ($urandom_range(0, 3) != 0) begin
        push_event(KIND_TICK, 6'($urandom));
      end else begin
        presses = {$urandom_range(0, 99) < 35, $urandom_range(0, 99) < 35,
                   $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 15,
                   $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 12};
        push_event(KIND_BUTTON, presses);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/shsc_pkg.sv
hw/rtl/stepper_half_step_controller.sv
dv/stepper_half_step_controller_test.sv
